// File: rtl/sbf_pkg.sv
// sbf_pkg: shared types and constants of the surface blur filter
// holds accumulator widths, opcodes, register indexes and divider structs
// no dependencies
package sbf_pkg;

   // opcodes carried on req_tuser
   localparam logic OP_STORE  = 1'b0;
   localparam logic OP_FILTER = 1'b1;

   // configuration register indexes
   localparam logic [1:0] CSR_RADIUS       = 2'd0;
   localparam logic [1:0] CSR_THRESHOLD    = 2'd1;
   localparam logic [1:0] CSR_FRAME_WIDTH  = 2'd2;
   localparam logic [1:0] CSR_FRAME_HEIGHT = 2'd3;

   // arithmetic widths, window is at most 31 x 31 pixels
   localparam int WT_W    = 17;  // q16 weight, up to 65536
   localparam int DROP_W  = 24;  // floor(d * 65536 / thr), d below 256
   localparam int SUMW_W  = 26;  // sum of up to 961 weights
   localparam int SUMWP_W = 34;  // sum of weight times pixel
   localparam int NUM_W   = 42;  // rounded dividend of the mean
   localparam int DEN_W   = 26;  // divisor width
   localparam int QUO_W   = 17;  // quotient bits produced per division

   localparam logic [WT_W-1:0] WT_ONE = 17'h10000;

   // divider request and response
   typedef struct packed {
      logic             start;
      logic [NUM_W-1:0] numer;
      logic [DEN_W-1:0] denom;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [QUO_W-1:0] quotient;
      logic [DEN_W-1:0] remainder;
   } div_rsp_type;

endpackage

// File: rtl/sbf_divider.sv
// sbf_divider: restoring divider, one quotient bit per cycle
// the dividend shifted right by QUO_W must be below the divisor
// depends on sbf_pkg
module sbf_divider (
   input  logic                clock,
   input  logic                reset,
   input  sbf_pkg::div_req_type div_req,
   output sbf_pkg::div_rsp_type div_rsp
);

   localparam int CNT_W = $clog2(sbf_pkg::QUO_W + 1);

   logic [sbf_pkg::DEN_W-1:0] rem_ff, rem_in;
   logic [sbf_pkg::QUO_W-1:0] low_ff, low_in;
   logic [sbf_pkg::QUO_W-1:0] quo_ff, quo_in;
   logic [sbf_pkg::DEN_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic [sbf_pkg::DEN_W:0]   trial;
   logic                      fits;

   // one restoring step on the partial remainder
   assign trial = {rem_ff, low_ff[sbf_pkg::QUO_W-1]};
   assign fits  = trial >= {1'b0, den_ff};

   always_comb begin
      rem_in   = rem_ff;
      low_in   = low_ff;
      quo_in   = quo_ff;
      den_in   = den_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (div_req.start) begin
         rem_in   = sbf_pkg::DEN_W'(div_req.numer[sbf_pkg::NUM_W-1:sbf_pkg::QUO_W]);
         low_in   = div_req.numer[sbf_pkg::QUO_W-1:0];
         den_in   = div_req.denom;
         quo_in   = '0;
         count_in = CNT_W'(sbf_pkg::QUO_W);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         rem_in   = fits ? sbf_pkg::DEN_W'(trial - {1'b0, den_ff})
                         : sbf_pkg::DEN_W'(trial);
         low_in   = {low_ff[sbf_pkg::QUO_W-2:0], 1'b0};
         quo_in   = {quo_ff[sbf_pkg::QUO_W-2:0], fits};
         count_in = count_ff - 1'b1;
         if (count_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      low_ff <= low_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quo_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

// File: rtl/surface_blur_filter.sv
// surface_blur_filter: edge-preserving blur over a stored 8-bit frame
// depends on sbf_pkg and sbf_divider
//
// req channel: one word per item. req_tuser is the opcode, 0 stores
// pixel_value at (pixel_row, pixel_col), 1 filters at that position.
// rsp channel: one word per filter item, the q8.8 weighted mean.
// csr channel: register writes (radius, threshold, frame_width,
// frame_height), always ready, to be written only while the block is idle.
//
// a store word is taken and holds req_tready high.
// a filter word, from its accept cycle on, reads the centre pixel, then
// each window pixel through the single frame memory read port, drains
// the read pipeline, launches the 17-step bit-serial division and
// collects its quotient, and loads the output register, at which
// rsp_tvalid rises. req_tready is low while a filter runs.
// after reset or a threshold write the first filter word first rebuilds
// the 256-entry weight table: one division of 65536 by the threshold,
// then a fill of all 256 entries.
// reset clears control state and loads the register defaults; frame
// contents are undefined until written. a stalled rsp word holds; the
// next filter may run meanwhile and waits at its end for the slot.
module surface_blur_filter #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256,
   parameter int MAX_RADIUS = 15
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // pixel_row[7:0], pixel_col[15:8], pixel_value[23:16]
   input  logic        req_tuser,  // opcode[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,  // filtered_value[15:0]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [9:0]  csr_data
);

   localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   typedef enum logic [10:0] {
      ST_IDLE    = 11'b000_0000_0001,
      ST_TDIV_GO = 11'b000_0000_0010,
      ST_TDIV    = 11'b000_0000_0100,
      ST_TFILL   = 11'b000_0000_1000,
      ST_CTR     = 11'b000_0001_0000,
      ST_CTRW    = 11'b000_0010_0000,
      ST_WIN     = 11'b000_0100_0000,
      ST_DRAIN   = 11'b000_1000_0000,
      ST_FDIV_GO = 11'b001_0000_0000,
      ST_FDIV    = 11'b010_0000_0000,
      ST_OUT     = 11'b100_0000_0000
   } state_type;

   state_type state_ff, state_in;

   // configuration
   logic [3:0] radius_ff, radius_in;
   logic [9:0] threshold_ff, threshold_in;
   logic [8:0] frame_width_ff, frame_width_in;
   logic [8:0] frame_height_ff, frame_height_in;
   logic       dirty_ff, dirty_in;

   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_data_ff, rsp_data_in;

   // filter context
   logic [7:0]  cr_ff, cr_in;
   logic [7:0]  cc_ff, cc_in;
   logic [7:0]  centre_ff, centre_in;
   logic signed [4:0] dy_ff, dy_in;
   logic signed [4:0] dx_ff, dx_in;

   // weight table build
   logic [7:0]                 d_ff, d_in;
   logic [sbf_pkg::DROP_W-1:0] q_ff, q_in;
   logic [9:0]                 r_ff, r_in;
   logic [sbf_pkg::QUO_W-1:0]  q0_ff, q0_in;
   logic [9:0]                 r0_ff, r0_in;

   // read pipeline and accumulators
   logic                        rd_valid_ff, rd_valid_in;
   logic                        wt_valid_ff, wt_valid_in;
   logic [7:0]                  frame_rd_ff;
   logic [7:0]                  pix_d_ff;
   logic [sbf_pkg::WT_W-1:0]    wt_rd_ff;
   logic [sbf_pkg::SUMW_W-1:0]  sum_w_ff, sum_w_in;
   logic [sbf_pkg::SUMWP_W-1:0] sum_wp_ff, sum_wp_in;

   // memories
   logic [7:0]               frame_mem [DEPTH];
   logic [sbf_pkg::WT_W-1:0] wtab_mem  [256];

   // combinational helpers
   logic              req_accept;
   logic [7:0]        req_row, req_col, req_value;
   logic              store_en;
   logic [ADDR_W-1:0] store_addr;
   logic [8:0]        eff_w, eff_h;
   logic [8:0]        lim_w, lim_h;
   logic [3:0]        rad_eff;
   logic signed [4:0] rad_s;
   logic [9:0]        thr_eff;
   logic [7:0]        row_clamp, col_clamp;
   logic signed [9:0] yy, xx;
   logic [8:0]        win_row, win_col;
   logic [8:0]        sel_row, sel_col;
   logic [ADDR_W-1:0] frame_raddr;
   logic [7:0]        diff;
   logic              wtab_we;
   logic [sbf_pkg::WT_W-1:0] wtab_wdata;
   logic [sbf_pkg::WT_W+7:0] wp_prod;
   logic [10:0]       r_sum;
   logic              win_last;
   logic [sbf_pkg::NUM_W-1:0] mean_numer;
   sbf_pkg::div_req_type div_req;
   sbf_pkg::div_rsp_type div_rsp;

   assign req_row    = req_tdata[7:0];
   assign req_col    = req_tdata[15:8];
   assign req_value  = req_tdata[23:16];
   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // effective frame size, radius and threshold
   always_comb begin
      eff_w = frame_width_ff;
      if (frame_width_ff == 9'd0) begin
         eff_w = 9'd1;
      end else if (32'(frame_width_ff) > MAX_WIDTH) begin
         eff_w = 9'(MAX_WIDTH);
      end
      eff_h = frame_height_ff;
      if (frame_height_ff == 9'd0) begin
         eff_h = 9'd1;
      end else if (32'(frame_height_ff) > MAX_HEIGHT) begin
         eff_h = 9'(MAX_HEIGHT);
      end
      rad_eff = (32'(radius_ff) > MAX_RADIUS) ? 4'(MAX_RADIUS) : radius_ff;
      thr_eff = (threshold_ff == 10'd0) ? 10'd1 : threshold_ff;
   end

   assign lim_w = eff_w - 9'd1;
   assign lim_h = eff_h - 9'd1;
   assign rad_s = $signed({1'b0, rad_eff});

   // centre position clamped to the frame
   assign row_clamp = ({1'b0, req_row} > lim_h) ? lim_h[7:0] : req_row;
   assign col_clamp = ({1'b0, req_col} > lim_w) ? lim_w[7:0] : req_col;

   // store address, writes beyond the array are dropped
   assign store_en   = req_accept && (req_tuser == sbf_pkg::OP_STORE)
                       && (32'(req_row) < MAX_HEIGHT) && (32'(req_col) < MAX_WIDTH);
   assign store_addr = ADDR_W'(32'(req_row) * MAX_WIDTH + 32'(req_col));

   // window coordinate with border replication
   assign yy = $signed({2'b00, cr_ff}) + {{5{dy_ff[4]}}, dy_ff};
   assign xx = $signed({2'b00, cc_ff}) + {{5{dx_ff[4]}}, dx_ff};

   always_comb begin
      if (yy[9]) begin
         win_row = 9'd0;
      end else if (yy[8:0] > lim_h) begin
         win_row = lim_h;
      end else begin
         win_row = yy[8:0];
      end
      if (xx[9]) begin
         win_col = 9'd0;
      end else if (xx[8:0] > lim_w) begin
         win_col = lim_w;
      end else begin
         win_col = xx[8:0];
      end
   end

   assign sel_row     = (state_ff == ST_CTR) ? {1'b0, cr_ff} : win_row;
   assign sel_col     = (state_ff == ST_CTR) ? {1'b0, cc_ff} : win_col;
   assign frame_raddr = ADDR_W'(32'(sel_row) * MAX_WIDTH + 32'(sel_col));

   // frame memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (store_en) begin
         frame_mem[store_addr] <= req_value;
      end
      frame_rd_ff <= frame_mem[frame_raddr];
   end

   // weight table, indexed by absolute difference to the centre
   assign diff       = (frame_rd_ff > centre_ff) ? frame_rd_ff - centre_ff
                                                 : centre_ff - frame_rd_ff;
   assign wtab_we    = (state_ff == ST_TFILL);
   assign wtab_wdata = (q_ff >= sbf_pkg::DROP_W'(sbf_pkg::WT_ONE)) ? '0
                       : sbf_pkg::WT_ONE - sbf_pkg::WT_W'(q_ff);

   always_ff @(posedge clock) begin
      if (wtab_we) begin
         wtab_mem[d_ff] <= wtab_wdata;
      end
      wt_rd_ff <= wtab_mem[diff];
      pix_d_ff <= frame_rd_ff;
   end

   // weight times pixel at full width
   assign wp_prod = wt_rd_ff * pix_d_ff;

   // shared divider: 65536 / threshold for the table, then the mean
   assign mean_numer = {sum_wp_ff, 8'b0} + sbf_pkg::NUM_W'(sum_w_ff >> 1);

   always_comb begin
      div_req.start = (state_ff == ST_TDIV_GO) || (state_ff == ST_FDIV_GO);
      if (state_ff == ST_TDIV_GO) begin
         div_req.numer = sbf_pkg::NUM_W'(sbf_pkg::WT_ONE);
         div_req.denom = sbf_pkg::DEN_W'(thr_eff);
      end else begin
         div_req.numer = mean_numer;
         div_req.denom = sum_w_ff;
      end
   end

   sbf_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign r_sum    = {1'b0, r_ff} + {1'b0, r0_ff};
   assign win_last = (dx_ff == rad_s) && (dy_ff == rad_s);

   // sequencer and next values
   always_comb begin
      state_in        = state_ff;
      radius_in       = radius_ff;
      threshold_in    = threshold_ff;
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      dirty_in        = dirty_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_tready;
      rsp_data_in     = rsp_data_ff;
      cr_in           = cr_ff;
      cc_in           = cc_ff;
      centre_in       = centre_ff;
      dy_in           = dy_ff;
      dx_in           = dx_ff;
      d_in            = d_ff;
      q_in            = q_ff;
      r_in            = r_ff;
      q0_in           = q0_ff;
      r0_in           = r0_ff;
      rd_valid_in     = (state_ff == ST_WIN);
      wt_valid_in     = rd_valid_ff;
      sum_w_in        = sum_w_ff;
      sum_wp_in       = sum_wp_ff;

      // register writes
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            sbf_pkg::CSR_RADIUS: radius_in = csr_data[3:0];
            sbf_pkg::CSR_THRESHOLD: begin
               threshold_in = csr_data;
               dirty_in     = 1'b1;
            end
            sbf_pkg::CSR_FRAME_WIDTH:  frame_width_in  = csr_data[8:0];
            sbf_pkg::CSR_FRAME_HEIGHT: frame_height_in = csr_data[8:0];
            default: ;
         endcase
      end

      // accumulate one weighted pixel
      if (wt_valid_ff) begin
         sum_w_in  = sum_w_ff + sbf_pkg::SUMW_W'(wt_rd_ff);
         sum_wp_in = sum_wp_ff + sbf_pkg::SUMWP_W'(wp_prod);
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && (req_tuser == sbf_pkg::OP_FILTER)) begin
               cr_in    = row_clamp;
               cc_in    = col_clamp;
               state_in = dirty_ff ? ST_TDIV_GO : ST_CTR;
            end
         end
         ST_TDIV_GO: state_in = ST_TDIV;
         ST_TDIV: begin
            if (div_rsp.done) begin
               q0_in    = div_rsp.quotient;
               r0_in    = div_rsp.remainder[9:0];
               d_in     = 8'd0;
               q_in     = '0;
               r_in     = 10'd0;
               state_in = ST_TFILL;
            end
         end
         ST_TFILL: begin
            // step drop(d) to drop(d+1) keeping quotient and remainder
            d_in = d_ff + 8'd1;
            if (r_sum >= {1'b0, thr_eff}) begin
               r_in = 10'(r_sum - {1'b0, thr_eff});
               q_in = q_ff + sbf_pkg::DROP_W'(q0_ff) + sbf_pkg::DROP_W'(1);
            end else begin
               r_in = r_sum[9:0];
               q_in = q_ff + sbf_pkg::DROP_W'(q0_ff);
            end
            if (d_ff == 8'd255) begin
               dirty_in = 1'b0;
               state_in = ST_CTR;
            end
         end
         ST_CTR: state_in = ST_CTRW;
         ST_CTRW: begin
            centre_in = frame_rd_ff;
            dy_in     = -rad_s;
            dx_in     = -rad_s;
            sum_w_in  = '0;
            sum_wp_in = '0;
            state_in  = ST_WIN;
         end
         ST_WIN: begin
            if (dx_ff == rad_s) begin
               dx_in = -rad_s;
               dy_in = dy_ff + 5'sd1;
            end else begin
               dx_in = dx_ff + 5'sd1;
            end
            if (win_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!rd_valid_ff && !wt_valid_ff) begin
               state_in = ST_FDIV_GO;
            end
         end
         ST_FDIV_GO: state_in = ST_FDIV;
         ST_FDIV: begin
            if (div_rsp.done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            // quotient stays in the idle divider until the slot frees
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = div_rsp.quotient[15:0];
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         radius_ff       <= 4'd5;
         threshold_ff    <= 10'd50;
         frame_width_ff  <= 9'd256;
         frame_height_ff <= 9'd256;
         dirty_ff        <= 1'b1;
         rsp_valid_ff    <= 1'b0;
         rd_valid_ff     <= 1'b0;
         wt_valid_ff     <= 1'b0;
      end else begin
         state_ff        <= state_in;
         radius_ff       <= radius_in;
         threshold_ff    <= threshold_in;
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
         dirty_ff        <= dirty_in;
         rsp_valid_ff    <= rsp_valid_in;
         rd_valid_ff     <= rd_valid_in;
         wt_valid_ff     <= wt_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      cr_ff       <= cr_in;
      cc_ff       <= cc_in;
      centre_ff   <= centre_in;
      dy_ff       <= dy_in;
      dx_ff       <= dx_in;
      d_ff        <= d_in;
      q_ff        <= q_in;
      r_ff        <= r_in;
      q0_ff       <= q0_in;
      r0_ff       <= r0_in;
      sum_w_ff    <= sum_w_in;
      sum_wp_ff   <= sum_wp_in;
   end

endmodule

// File: rtl/sbf_checker.sv
// sbf_checker: port-level assertions for surface_blur_filter
// attached to the top level by the bind statement at the end of this file
// no package dependencies
module sbf_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [23:0] req_tdata,
   input logic        req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);

   // no result word right after reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp word valid after reset");

   // a stalled result word holds its value
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled rsp word changed");

   // a filter word occupies the block
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser |=> !req_tready)
      else $error("ready while a filter runs");

   // a store word finishes at once
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !req_tuser |=> req_tready)
      else $error("store word stalled the block");

   // the mean never exceeds 255 in q8.8
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata <= 16'hFF00)
      else $error("rsp word above full scale");

endmodule

bind surface_blur_filter sbf_checker u_sbf_checker (.*);
